// ===== hdl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants for the rgb to hsv converter pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int unsigned ChanW   = 8;   // width of one color channel
  localparam int unsigned HueW    = 9;
  localparam int unsigned PctW    = 7;
  localparam int unsigned RemW    = 15;  // holds 100 * 255
  localparam int unsigned QuoW    = 7;   // quotients stay below 128
  localparam int unsigned NumCell = QuoW;

  localparam logic [HueW-1:0] HueOffRed   = 9'd0;
  localparam logic [HueW-1:0] HueOffWrap  = 9'd360;
  localparam logic [HueW-1:0] HueOffGreen = 9'd120;
  localparam logic [HueW-1:0] HueOffBlue  = 9'd240;

  // one pixel in flight through the divider row
  typedef struct packed {
    logic [RemW-1:0]  hue_rem;
    logic [QuoW-1:0]  hue_quo;
    logic [ChanW-1:0] hue_div;
    logic [RemW-1:0]  sat_rem;
    logic [QuoW-1:0]  sat_quo;
    logic [ChanW-1:0] sat_div;
    logic [HueW-1:0]  hue_off;
    logic             hue_neg;
    logic [PctW-1:0]  val;
  } rhc_beat_t;

endpackage

`default_nettype wire

// ===== hdl/rhc_prep.sv =====
// ----------------------------------------------------------------------------
// rhc_prep
// front stage: max, min, hue sector, numerators and divisors, value percent
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_prep
  import rhc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [ChanW-1:0] red_i,
  input  wire logic [ChanW-1:0] green_i,
  input  wire logic [ChanW-1:0] blue_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rhc_beat_t             beat_o
);

  logic             valid_q;
  rhc_beat_t        beat_d, beat_q;
  logic [ChanW-1:0] mx, mn, delta, hp, hq, diff;
  logic [RemW-1:0]  val_x;
  logic [RemW:0]    val_t;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;

    beat_d = '0;
    // sector select, red wins ties, then green
    if (delta == '0) begin
      hp = '0;
      hq = '0;
      beat_d.hue_off = HueOffRed;
    end else if (mx == red_i) begin
      hp = green_i;
      hq = blue_i;
      beat_d.hue_off = (green_i >= blue_i) ? HueOffRed : HueOffWrap;
    end else if (mx == green_i) begin
      hp = blue_i;
      hq = red_i;
      beat_d.hue_off = HueOffGreen;
    end else begin
      hp = red_i;
      hq = green_i;
      beat_d.hue_off = HueOffBlue;
    end
    beat_d.hue_neg = (hp < hq);
    diff = beat_d.hue_neg ? (hq - hp) : (hp - hq);
    beat_d.hue_rem = RemW'(diff) * RemW'(60);
    beat_d.hue_div = (delta == '0) ? ChanW'(1) : delta;

    // a black pixel divides zero by one
    beat_d.sat_rem = RemW'(delta) * RemW'(100);
    beat_d.sat_div = (mx == '0) ? ChanW'(1) : mx;

    // floor(x / 255) as (x + x/256 + 1) / 256, exact over this range
    val_x = RemW'(mx) * RemW'(100);
    val_t = (RemW+1)'(val_x) + (RemW+1)'(val_x >> 8) + (RemW+1)'(1);
    beat_d.val = val_t[8 +: PctW];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

// ===== hdl/rhc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_div_cell
// one restoring divide step for hue and saturation, one quotient bit each
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_cell
  import rhc_pkg::*;
#(
  parameter int unsigned Shift = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire rhc_beat_t beat_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output rhc_beat_t      beat_o
);

  logic            valid_q;
  rhc_beat_t       beat_d, beat_q;
  logic [RemW:0]   hue_sub, sat_sub;

  always_comb begin
    beat_d  = beat_i;
    hue_sub = (RemW+1)'(beat_i.hue_div) << Shift;
    sat_sub = (RemW+1)'(beat_i.sat_div) << Shift;
    if ((RemW+1)'(beat_i.hue_rem) >= hue_sub) begin
      beat_d.hue_rem        = beat_i.hue_rem - hue_sub[RemW-1:0];
      beat_d.hue_quo[Shift] = 1'b1;
    end
    if ((RemW+1)'(beat_i.sat_rem) >= sat_sub) begin
      beat_d.sat_rem        = beat_i.sat_rem - sat_sub[RemW-1:0];
      beat_d.sat_quo[Shift] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

// ===== hdl/rhc_post.sv =====
// ----------------------------------------------------------------------------
// rhc_post
// output register: applies hue offset and rounding direction
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_post
  import rhc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire rhc_beat_t       beat_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output logic [HueW-1:0]      hue_o,
  output logic [PctW-1:0]      sat_o,
  output logic [PctW-1:0]      val_o
);

  logic            valid_q;
  logic [HueW-1:0] hue_d, hue_q, hue_ceil;
  logic [PctW-1:0] sat_q, val_q;

  always_comb begin
    // negative side rounds the magnitude up so the sum rounds down
    hue_ceil = HueW'(beat_i.hue_quo) + HueW'(beat_i.hue_rem != '0);
    hue_d    = beat_i.hue_neg ? (beat_i.hue_off - hue_ceil)
                              : (beat_i.hue_off + HueW'(beat_i.hue_quo));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q <= hue_d;
      sat_q <= beat_i.sat_quo;
      val_q <= beat_i.val;
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hsv_converter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// streaming rgb to hsv pixel converter built from a row of divider cells
// ----------------------------------------------------------------------------
// pipeline: front stage, 7 divider cells and the output register, each registered
// throughput: one pixel per cycle; every stage holds one pixel and moves on
//   whenever the stage after it is empty or moving
// reset: rst_ni clears all stage valid flags asynchronously; payload is not
//   reset
`default_nettype none

module rgb_to_hsv_converter_core
  import rhc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel in: [7:0] red, [15:8] green, [23:16] blue
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  // result out: [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata
);

  // handshake and payload between neighbors in the row
  logic      valid_w [NumCell+1];
  logic      ready_w [NumCell+1];
  rhc_beat_t beat_w  [NumCell+1];

  logic [HueW-1:0] hue;
  logic [PctW-1:0] saturation, brightness;

  // front stage: extremes, sector choice, numerators, value percent
  rhc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (valid_w[0]),
    .ready_i (ready_w[0]),
    .beat_o  (beat_w[0])
  );

  // divider row: cell k resolves quotient bit (msb - k) of both divisions
  for (genvar k = 0; k < NumCell; k++) begin : g_cell
    rhc_div_cell #(
      .Shift (NumCell - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .ready_o (ready_w[k]),
      .beat_i  (beat_w[k]),
      .valid_o (valid_w[k+1]),
      .ready_i (ready_w[k+1]),
      .beat_o  (beat_w[k+1])
    );
  end

  // output register: hue offset with floor on the negative side
  rhc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_w[NumCell]),
    .ready_o (ready_w[NumCell]),
    .beat_i  (beat_w[NumCell]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .hue_o   (hue),
    .sat_o   (saturation),
    .val_o   (brightness)
  );

  // pack result fields, lowest first, padded to whole bytes
  assign m_axis_tdata = {1'b0, brightness, saturation, hue};

endmodule

`default_nettype wire

// ===== tb/rgb_to_hsv_converter_core_test.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core_test
// self-checking bench for the streaming rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// the bench sends pixels on the slave stream and computes the expected hue,
// saturation and value for each accepted beat with an integer floor-division
// model. it queues each expected result and compares every output beat, field
// by field, with the oldest one in the queue. it starts with corner pixels,
// then uniform random pixels, then near-gray and tied-maximum pixels, and
// ends with a stretch at full rate. both sides idle at random except in
// the full rate stretch.
`default_nettype none

module rgb_to_hsv_converter_core_test;
  import rhc_pkg::*;

  localparam int unsigned DegPerSector = 60;
  localparam int unsigned PctScale     = 100;
  localparam int unsigned ChanMax      = 255;
  localparam int unsigned MaxIdle      = 10;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned CycleLimit   = 200_000;
  localparam int unsigned MaxReports   = 10;

  // pixel as it sits on s_axis_tdata, red in the lowest byte
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  // result as it sits on m_axis_tdata, top bit is zero fill
  typedef struct packed {
    logic            fill;
    logic [PctW-1:0] brightness;
    logic [PctW-1:0] saturation;
    logic [HueW-1:0] hue;
  } hsv_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  hsv_t        hsv_expected[$];
  bit          idle_on = 1'b1;
  int unsigned ready_stall = 0;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  int unsigned corner_pixels = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;

  rgb_to_hsv_converter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // hsv model
  // ---------------------------------------------------------------------------

  // off + floor(60 * (p - q) / d), the difference may be negative
  function automatic int unsigned sector_hue(int unsigned off, int unsigned p,
                                             int unsigned q, int unsigned d);
    if (p >= q) begin
      return off + (DegPerSector * (p - q)) / d;
    end
    return off - (DegPerSector * (q - p) + d - 1) / d;
  endfunction

  function automatic hsv_t hsv_of(pixel_t px);
    int unsigned r, g, b, mx, mn, d, h;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // red wins ties for the maximum, then green
    if (d == 0) begin
      h = 0;
    end else if (mx == r) begin
      h = (g >= b) ? sector_hue(HueOffRed, g, b, d) : sector_hue(HueOffWrap, g, b, d);
    end else if (mx == g) begin
      h = sector_hue(HueOffGreen, b, r, d);
    end else begin
      h = sector_hue(HueOffBlue, r, g, d);
    end
    res.fill       = 1'b0;
    res.hue        = h[HueW-1:0];
    res.saturation = (mx == 0) ? '0 : PctW'((PctScale * d) / mx);
    res.brightness = PctW'((PctScale * mx) / ChanMax);
    return res;
  endfunction

  function automatic pixel_t rgb(int unsigned r, int unsigned g, int unsigned b);
    pixel_t px;
    px.red   = r[ChanW-1:0];
    px.green = g[ChanW-1:0];
    px.blue  = b[ChanW-1:0];
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    hsv_expected.push_back(hsv_of(px));
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure and the field by field compare
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (ready_stall > 0) begin
      m_axis_tready <= 1'b0;
      ready_stall = ready_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    hsv_t got, want;
    got = m_axis_tdata;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      ready_stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (hsv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result beat with nothing expected: hue %0d sat %0d val %0d",
                   got.hue, got.saturation, got.brightness);
        end
      end else begin
        want = hsv_expected.pop_front();
        results_checked++;
        if (got.hue !== want.hue || got.saturation !== want.saturation ||
            got.brightness !== want.brightness || got.fill !== want.fill) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result %0d: expected hue %0d sat %0d val %0d fill %0b",
                     results_checked, want.hue, want.saturation, want.brightness,
                     want.fill);
            $display("result %0d:      got hue %0d sat %0d val %0d fill %0b",
                     results_checked, got.hue, got.saturation, got.brightness,
                     got.fill);
          end
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               hsv_expected.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, gray, black, ties and every hue sector with both signs
  task automatic test_corner_pixels();
    send_pixel(rgb(0, 0, 0));        // black
    send_pixel(rgb(255, 255, 255));  // white
    send_pixel(rgb(128, 128, 128));  // gray
    send_pixel(rgb(1, 1, 1));
    send_pixel(rgb(1, 0, 0));        // tiny max, full saturation
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(0, 255, 0));
    send_pixel(rgb(0, 0, 255));
    send_pixel(rgb(255, 255, 0));    // red ties green
    send_pixel(rgb(255, 0, 255));    // red ties blue
    send_pixel(rgb(0, 255, 255));    // green ties blue
    send_pixel(rgb(200, 200, 7));
    send_pixel(rgb(255, 1, 0));      // red max, green above blue
    send_pixel(rgb(255, 0, 1));      // red max, wraps to 359
    send_pixel(rgb(1, 255, 0));      // green max, below 120
    send_pixel(rgb(0, 255, 1));      // green max, blue above red, floors to 120
    send_pixel(rgb(1, 0, 255));      // blue max, red above green, floors to 240
    send_pixel(rgb(0, 1, 255));      // blue max, below 240
    send_pixel(rgb(10, 9, 9));       // delta of one
    send_pixel(rgb(254, 255, 253));
    send_pixel(rgb(170, 85, 255));
    send_pixel(rgb(254, 254, 255));
    corner_pixels = pixels_sent;
  endtask

  task automatic test_random_pixels(int unsigned count);
    repeat (count) begin
      send_pixel(rgb($urandom_range(0, ChanMax), $urandom_range(0, ChanMax),
                     $urandom_range(0, ChanMax)));
    end
  endtask

  // small deltas stress the hue rounding, ties stress the sector choice
  task automatic test_near_gray_and_ties(int unsigned count);
    int unsigned base, other, c[3], k;
    repeat (count) begin
      base = $urandom_range(0, ChanMax);
      if ($urandom_range(0, 1)) begin
        for (k = 0; k < 3; k++) begin
          c[k] = base + $urandom_range(0, 6);
          c[k] = (c[k] < 3) ? 0 : c[k] - 3;
          if (c[k] > ChanMax) c[k] = ChanMax;
        end
      end else begin
        other = $urandom_range(0, base);
        k = $urandom_range(0, 2);
        c[0] = base;
        c[1] = base;
        c[2] = base;
        c[k] = other;
      end
      send_pixel(rgb(c[0], c[1], c[2]));
    end
  endtask

  // no gaps and no backpressure: one pixel every cycle
  task automatic test_full_rate(int unsigned count);
    idle_on = 1'b0;
    test_random_pixels(count);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_pixels();
    test_random_pixels(280);
    test_near_gray_and_ties(150);
    test_full_rate(100);

    s_axis_tvalid <= 1'b0;
    while (hsv_expected.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d pixels (%0d corner cases), checked %0d results in %0d cycles",
             pixels_sent, corner_pixels, results_checked, cycles);
    $display("mismatches or stray results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
